### rtl/mfd_pkg.sv
// ----------------------------------------------------------------------------
// mfd_pkg
// Shared types and constants of the max-flow block: field widths, datapath
// operation codes and the status word returned to the controller.
// ----------------------------------------------------------------------------
package mfd_pkg;

	localparam int VERT_W = 3;
	localparam int CAP_W  = 16;
	localparam int FLOW_W = 19;

	localparam logic KIND_LOAD    = 1'b0;
	localparam logic KIND_COMPUTE = 1'b1;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_CLEAR,
		OP_LOAD,
		OP_START,
		OP_COPY_RD,
		OP_COPY_WR,
		OP_SEARCH_INIT,
		OP_SCAN_SETUP,
		OP_SCAN_RD,
		OP_SCAN_EVAL,
		OP_POP,
		OP_WALK_INIT,
		OP_WALK_RD,
		OP_WALK_EVAL,
		OP_AUG_INIT,
		OP_AUG_RD_F,
		OP_AUG_WR_F,
		OP_AUG_RD_B,
		OP_AUG_WR_B,
		OP_ADD_FLOW,
		OP_EMIT
	} dp_op_t;

	typedef struct packed {
		logic cnt_last;
		logic bad_vertex;
		logic v_end;
		logic hit;
		logic hit_dst;
		logic last_pop;
		logic at_src;
	} dp_stat_t;

	typedef struct packed {
		logic [VERT_W-1:0] row;
		logic [VERT_W-1:0] col;
		logic [CAP_W-1:0]  capacity;
		logic [VERT_W-1:0] source;
		logic [VERT_W-1:0] sink;
	} req_data_t;

endpackage

### rtl/mfd_req_if.sv
// ----------------------------------------------------------------------------
// mfd_req_if
// Request channel: load and compute items with valid/ready handshake.
// ----------------------------------------------------------------------------
interface mfd_req_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [2:0]  row;
	logic [2:0]  col;
	logic [15:0] capacity;
	logic [2:0]  source;
	logic [2:0]  sink;

	modport source_mp (output valid, kind, row, col, capacity, source, sink, input ready);
	modport sink_mp (input valid, kind, row, col, capacity, source, sink, output ready);
endinterface

### rtl/mfd_rsp_if.sv
// ----------------------------------------------------------------------------
// mfd_rsp_if
// Response channel: total flow with valid/ready handshake.
// ----------------------------------------------------------------------------
interface mfd_rsp_if;
	logic        valid;
	logic        ready;
	logic [18:0] flow_sum;

	modport source_mp (output valid, flow_sum, input ready);
	modport sink_mp (input valid, flow_sum, output ready);
endinterface

### rtl/mfd_ram.sv
// ----------------------------------------------------------------------------
// mfd_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module mfd_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

### rtl/mfd_dp.sv
// ----------------------------------------------------------------------------
// mfd_dp
// Datapath: capacity and residual memories, search stack, visited marks,
// parent links, path minimum and flow accumulator. Executes one operation
// code from the controller per cycle and reports status back.
// ----------------------------------------------------------------------------
module mfd_dp #(
	parameter int NODES    = 8,
	parameter int CAP_BITS = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  mfd_pkg::dp_op_t           op,
	input  mfd_pkg::req_data_t        req_data,
	output mfd_pkg::dp_stat_t         stat,
	output logic [mfd_pkg::FLOW_W-1:0] flow_sum
);
	import mfd_pkg::*;

	localparam int IDX_W  = (NODES > 1) ? $clog2(NODES) : 1;
	localparam int DEP_W  = $clog2(NODES + 1);
	localparam int ENTRY  = NODES * NODES;
	localparam int ADDR_W = $clog2(ENTRY);
	localparam int RES_W  = CAP_BITS + 1;

	logic [ADDR_W-1:0] cnt_q;
	logic [IDX_W-1:0]  src_q;
	logic [IDX_W-1:0]  dst_q;
	logic              bad_q;
	logic              vis_q [NODES];
	logic [IDX_W-1:0]  par_q [NODES];
	logic [IDX_W-1:0]  stk_v_q [NODES];
	logic [IDX_W:0]    stk_r_q [NODES];
	logic [DEP_W-1:0]  depth_q;
	logic [IDX_W:0]    v_q;
	logic [IDX_W-1:0]  walk_q;
	logic [RES_W-1:0]  amt_q;
	logic [FLOW_W-1:0] flow_q;
	logic [FLOW_W-1:0] out_q;

	logic              cap_we;
	logic [ADDR_W-1:0] cap_waddr;
	logic [CAP_BITS-1:0] cap_wdata;
	logic [CAP_BITS-1:0] cap_rdata;
	logic              res_we;
	logic [ADDR_W-1:0] res_waddr;
	logic [RES_W-1:0]  res_wdata;
	logic [ADDR_W-1:0] res_raddr;
	logic [RES_W-1:0]  res_rdata;

	logic [IDX_W-1:0]  top_idx;
	logic [IDX_W-1:0]  top_u;
	logic [IDX_W-1:0]  v_idx;
	logic [IDX_W-1:0]  par_w;
	logic              load_ok;

	function automatic logic [ADDR_W-1:0] addr_of(input logic [IDX_W-1:0] u,
			input logic [IDX_W-1:0] v);
		return ADDR_W'(int'(u) * NODES + int'(v));
	endfunction

	assign top_idx = IDX_W'(depth_q - 1'b1);
	assign top_u   = stk_v_q[top_idx];
	assign v_idx   = v_q[IDX_W-1:0];
	assign par_w   = par_q[walk_q];
	assign load_ok = (int'(req_data.row) < NODES) && (int'(req_data.col) < NODES);

	mfd_ram #(.WIDTH(CAP_BITS), .DEPTH(ENTRY)) u_cap_ram (
		.clk   (clk),
		.we    (cap_we),
		.waddr (cap_waddr),
		.wdata (cap_wdata),
		.raddr (cnt_q),
		.rdata (cap_rdata)
	);

	mfd_ram #(.WIDTH(RES_W), .DEPTH(ENTRY)) u_res_ram (
		.clk   (clk),
		.we    (res_we),
		.waddr (res_waddr),
		.wdata (res_wdata),
		.raddr (res_raddr),
		.rdata (res_rdata)
	);

	always_comb begin
		cap_we    = 1'b0;
		cap_waddr = cnt_q;
		cap_wdata = '0;
		res_we    = 1'b0;
		res_waddr = cnt_q;
		res_wdata = RES_W'(cap_rdata);
		res_raddr = '0;
		case (op)
			OP_CLEAR: begin
				cap_we = 1'b1;
			end
			OP_LOAD: begin
				cap_we    = load_ok;
				cap_waddr = ADDR_W'(int'(req_data.row) * NODES + int'(req_data.col));
				cap_wdata = CAP_BITS'(req_data.capacity);
			end
			OP_COPY_WR: begin
				res_we = 1'b1;
			end
			OP_SCAN_RD: begin
				res_raddr = addr_of(top_u, v_idx);
			end
			OP_WALK_RD, OP_AUG_RD_F: begin
				res_raddr = addr_of(par_w, walk_q);
			end
			OP_AUG_RD_B: begin
				res_raddr = addr_of(walk_q, par_w);
			end
			OP_AUG_WR_F: begin
				res_we    = 1'b1;
				res_waddr = addr_of(par_w, walk_q);
				res_wdata = res_rdata - amt_q;
			end
			OP_AUG_WR_B: begin
				res_we    = 1'b1;
				res_waddr = addr_of(walk_q, par_w);
				res_wdata = res_rdata + amt_q;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		stat.cnt_last   = (cnt_q == ADDR_W'(ENTRY - 1));
		stat.bad_vertex = bad_q;
		stat.v_end      = (v_q == (IDX_W + 1)'(NODES));
		stat.hit        = !vis_q[v_idx] && (res_rdata != '0);
		stat.hit_dst    = (v_idx == dst_q);
		stat.last_pop   = (depth_q == DEP_W'(1));
		stat.at_src     = (walk_q == src_q);
	end

	// Control counters and visited marks come out of reset cleared.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			depth_q <= '0;
			flow_q  <= '0;
			out_q   <= '0;
			bad_q   <= 1'b0;
			for (int i = 0; i < NODES; i++) begin
				vis_q[i] <= 1'b0;
			end
		end else begin
			case (op)
				OP_CLEAR, OP_COPY_WR: begin
					cnt_q <= cnt_q + 1'b1;
				end
				OP_START: begin
					cnt_q  <= '0;
					flow_q <= '0;
					bad_q  <= !((int'(req_data.source) < NODES) &&
						(int'(req_data.sink) < NODES));
				end
				OP_SEARCH_INIT: begin
					for (int i = 0; i < NODES; i++) begin
						vis_q[i] <= (IDX_W'(i) == src_q);
					end
					depth_q <= DEP_W'(1);
				end
				OP_SCAN_EVAL: begin
					if (stat.hit && !stat.hit_dst) begin
						vis_q[v_idx] <= 1'b1;
						depth_q      <= depth_q + 1'b1;
					end
				end
				OP_POP: begin
					depth_q <= depth_q - 1'b1;
				end
				OP_ADD_FLOW: begin
					flow_q <= flow_q + FLOW_W'(amt_q);
				end
				OP_EMIT: begin
					out_q <= flow_q;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (op)
			OP_START: begin
				src_q <= IDX_W'(req_data.source);
				dst_q <= IDX_W'(req_data.sink);
			end
			OP_SEARCH_INIT: begin
				stk_v_q[0] <= src_q;
				stk_r_q[0] <= '0;
			end
			OP_SCAN_SETUP: begin
				v_q <= stk_r_q[top_idx];
			end
			OP_SCAN_EVAL: begin
				if (stat.hit) begin
					par_q[v_idx] <= top_u;
					if (!stat.hit_dst) begin
						stk_r_q[top_idx]        <= v_q + 1'b1;
						stk_v_q[IDX_W'(depth_q)] <= v_idx;
						stk_r_q[IDX_W'(depth_q)] <= '0;
					end
				end else begin
					v_q <= v_q + 1'b1;
				end
			end
			OP_WALK_INIT: begin
				walk_q <= dst_q;
				amt_q  <= '1;
			end
			OP_WALK_EVAL: begin
				if (res_rdata < amt_q) begin
					amt_q <= res_rdata;
				end
				walk_q <= par_w;
			end
			OP_AUG_INIT: begin
				walk_q <= dst_q;
			end
			OP_AUG_WR_B: begin
				walk_q <= par_w;
			end
			default: begin
			end
		endcase
	end

	assign flow_sum = out_q;
endmodule

### rtl/mfd_ctrl.sv
// ----------------------------------------------------------------------------
// mfd_ctrl
// Controller: sequences the clearing pass, loads, the residual copy, the
// depth-first search, the path minimum walk and the augment walk.
// ----------------------------------------------------------------------------
module mfd_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  logic              req_kind,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	input  mfd_pkg::dp_stat_t stat,
	output mfd_pkg::dp_op_t   op
);
	import mfd_pkg::*;

	typedef enum logic [4:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_COPY_RD,
		ST_COPY_WR,
		ST_SEARCH,
		ST_SETUP,
		ST_CHECK,
		ST_SCAN_RD,
		ST_SCAN_EVAL,
		ST_POP,
		ST_WALK_INIT,
		ST_WALK_CHECK,
		ST_WALK_RD,
		ST_WALK_EVAL,
		ST_AUG_INIT,
		ST_AUG_CHECK,
		ST_AUG_RD_F,
		ST_AUG_WR_F,
		ST_AUG_RD_B,
		ST_AUG_WR_B,
		ST_FINISH
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   rsp_valid_q;
	logic   accept;
	logic   emit;

	assign req_ready = (state_q == ST_IDLE);
	assign accept    = req_valid && req_ready;
	assign rsp_valid = rsp_valid_q;
	// The result register is free when it is empty or is being read out.
	assign emit      = (state_q == ST_FINISH) && (!rsp_valid_q || rsp_ready);

	always_comb begin
		state_d = state_q;
		op      = OP_NONE;
		case (state_q)
			ST_CLEAR: begin
				op = OP_CLEAR;
				if (stat.cnt_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept) begin
					if (req_kind == KIND_COMPUTE) begin
						op      = OP_START;
						state_d = ST_COPY_RD;
					end else begin
						op = OP_LOAD;
					end
				end
			end
			ST_COPY_RD: begin
				op      = OP_COPY_RD;
				state_d = ST_COPY_WR;
			end
			ST_COPY_WR: begin
				op = OP_COPY_WR;
				if (!stat.cnt_last) state_d = ST_COPY_RD;
				else if (stat.bad_vertex) state_d = ST_FINISH;
				else state_d = ST_SEARCH;
			end
			ST_SEARCH: begin
				op      = OP_SEARCH_INIT;
				state_d = ST_SETUP;
			end
			ST_SETUP: begin
				op      = OP_SCAN_SETUP;
				state_d = ST_CHECK;
			end
			ST_CHECK: begin
				state_d = stat.v_end ? ST_POP : ST_SCAN_RD;
			end
			ST_SCAN_RD: begin
				op      = OP_SCAN_RD;
				state_d = ST_SCAN_EVAL;
			end
			ST_SCAN_EVAL: begin
				op = OP_SCAN_EVAL;
				if (stat.hit && stat.hit_dst) state_d = ST_WALK_INIT;
				else if (stat.hit) state_d = ST_SETUP;
				else state_d = ST_CHECK;
			end
			ST_POP: begin
				op      = OP_POP;
				state_d = stat.last_pop ? ST_FINISH : ST_SETUP;
			end
			ST_WALK_INIT: begin
				op      = OP_WALK_INIT;
				state_d = ST_WALK_CHECK;
			end
			ST_WALK_CHECK: begin
				state_d = stat.at_src ? ST_AUG_INIT : ST_WALK_RD;
			end
			ST_WALK_RD: begin
				op      = OP_WALK_RD;
				state_d = ST_WALK_EVAL;
			end
			ST_WALK_EVAL: begin
				op      = OP_WALK_EVAL;
				state_d = ST_WALK_CHECK;
			end
			ST_AUG_INIT: begin
				op      = OP_AUG_INIT;
				state_d = ST_AUG_CHECK;
			end
			ST_AUG_CHECK: begin
				if (stat.at_src) begin
					op      = OP_ADD_FLOW;
					state_d = ST_SEARCH;
				end else begin
					state_d = ST_AUG_RD_F;
				end
			end
			ST_AUG_RD_F: begin
				op      = OP_AUG_RD_F;
				state_d = ST_AUG_WR_F;
			end
			ST_AUG_WR_F: begin
				op      = OP_AUG_WR_F;
				state_d = ST_AUG_RD_B;
			end
			ST_AUG_RD_B: begin
				op      = OP_AUG_RD_B;
				state_d = ST_AUG_WR_B;
			end
			ST_AUG_WR_B: begin
				op      = OP_AUG_WR_B;
				state_d = ST_AUG_CHECK;
			end
			ST_FINISH: begin
				if (emit) begin
					op      = OP_EMIT;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end
endmodule

### rtl/max_flow_dfs_augment.sv
// ----------------------------------------------------------------------------
// max_flow_dfs_augment
// Ford-Fulkerson maximum flow with depth-first augmenting paths over a
// loaded capacity matrix.
//
//   Channel  Dir  Payload                                  Transaction
//   req      in   kind, row, col, capacity, source, sink   load or compute
//   rsp      out  flow_sum                                 one per compute
//
// A compute checks source and sink, copies the capacity matrix into the
// residual memory and, unless a vertex is out of range, repeats a depth-first
// search from the source, a minimum walk along the parent links from the sink
// and an augment walk until no path is found. The search tests the neighbors
// of the stack top in order, pushes on a hit and pops when none are left.
// After reset the capacity memory is zeroed; req is not ready until then. req
// is ready only while the controller is idle; a finished compute waits in its
// last state while the previous result is still held on rsp.
// ----------------------------------------------------------------------------
module max_flow_dfs_augment #(
	parameter int NODES    = 8,
	parameter int CAP_BITS = 16
) (
	input logic      clk,
	input logic      arst_n,
	mfd_req_if.sink_mp   req,
	mfd_rsp_if.source_mp rsp
);
	import mfd_pkg::*;

	dp_op_t    op;
	dp_stat_t  stat;
	req_data_t req_data;

	assign req_data.row      = req.row;
	assign req_data.col      = req.col;
	assign req_data.capacity = req.capacity;
	assign req_data.source   = req.source;
	assign req_data.sink     = req.sink;

	mfd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.req_kind  (req.kind),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.stat      (stat),
		.op        (op)
	);

	mfd_dp #(.NODES(NODES), .CAP_BITS(CAP_BITS)) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.op       (op),
		.req_data (req_data),
		.stat     (stat),
		.flow_sum (rsp.flow_sum)
	);
endmodule

### test/tb_scoreboard.sv
// ----------------------------------------------------------------------------
// tb_scoreboard
// Keeps the testbench's own copy of the capacity matrix, computes the expected
// maximum flow for each compute transaction and checks the returned totals.
// ----------------------------------------------------------------------------
package tb_scoreboard_pkg;
	timeunit 1ns;
	timeprecision 1ps;
	import mfd_pkg::*;

	localparam int NV = 8;

	class flow_scoreboard;
		logic [CAP_W-1:0]  cap_mem[NV][NV];
		logic [FLOW_W-1:0] pending_flows[$];
		int errors;

		function new();
			errors = 0;
			foreach (cap_mem[r, c]) cap_mem[r][c] = '0;
		endfunction

		// Depth-first search, lowest neighbor first, with a resume index per vertex.
		function bit find_path(ref logic [CAP_W:0] resid[NV][NV],
				ref int parent[NV], input int src, input int dst);
			bit seen[NV];
			int stk[NV];
			int resume[NV];
			int depth;
			int u;
			bit pushed;
			foreach (seen[i]) seen[i] = 0;
			seen[src] = 1;
			resume[src] = 0;
			depth = 0;
			stk[depth] = src;
			depth++;
			while (depth > 0) begin
				u = stk[depth-1];
				pushed = 0;
				for (int v = resume[u]; v < NV; v++) begin
					if (!seen[v] && resid[u][v] > 0) begin
						parent[v] = u;
						if (v == dst)
							return 1;
						resume[u] = v + 1;
						seen[v] = 1;
						resume[v] = 0;
						if (depth < NV) begin
							stk[depth] = v;
							depth++;
						end
						pushed = 1;
						break;
					end
				end
				if (!pushed) begin
					resume[u] = NV;
					depth--;
				end
			end
			return 0;
		endfunction

		function logic [FLOW_W-1:0] total_flow(int src, int dst);
			logic [CAP_W:0] resid[NV][NV];
			int parent[NV];
			longint total;
			longint amount;
			int v;
			foreach (resid[r, c]) resid[r][c] = {1'b0, cap_mem[r][c]};
			total = 0;
			while (find_path(resid, parent, src, dst)) begin
				amount = 64'h7fff_ffff_ffff;
				for (v = dst; v != src; v = parent[v])
					if (resid[parent[v]][v] < amount)
						amount = resid[parent[v]][v];
				for (v = dst; v != src; v = parent[v]) begin
					resid[parent[v]][v] -= (CAP_W + 1)'(amount);
					resid[v][parent[v]] += (CAP_W + 1)'(amount);
				end
				total += amount;
			end
			return total[FLOW_W-1:0];
		endfunction

		function void note_request(logic kind, logic [2:0] row, logic [2:0] col,
				logic [CAP_W-1:0] capacity, logic [2:0] source, logic [2:0] sink);
			if (kind == KIND_LOAD)
				cap_mem[row][col] = capacity;
			else
				pending_flows.push_back(total_flow(int'(source), int'(sink)));
		endfunction

		function void check_flow(logic [FLOW_W-1:0] flow);
			logic [FLOW_W-1:0] want;
			if (pending_flows.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %0d", $time, flow);
				errors++;
				return;
			end
			want = pending_flows.pop_front();
			if (flow !== want) begin
				$display("%0t: flow_sum mismatch, expected %0d, actual %0d",
					$time, want, flow);
				errors++;
			end
		endfunction
	endclass
endpackage

### test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Loads random and structured graphs into the max-flow block, starts
// computations with random source and sink, and checks each total against
// a software max-flow computation, under random idling on both channels.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import mfd_pkg::*;
	import tb_scoreboard_pkg::*;

	localparam int CYCLE_LIMIT = 20000000;

	logic clk;
	logic arst_n;
	int cycles;
	bit stall_mode;
	flow_scoreboard board;

	mfd_req_if req();
	mfd_rsp_if rsp();

	max_flow_dfs_augment dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req.sink_mp),
		.rsp(rsp.source_mp)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Receiver: stretches of steady ready alternate with random stalls.
	always @(posedge clk) begin
		if (rsp.valid && rsp.ready) begin
			board.check_flow(rsp.flow_sum);
		end
		if ($urandom_range(0, 99) < 3)
			stall_mode <= ~stall_mode;
		rsp.ready <= stall_mode ? ($urandom_range(0, 3) == 0) : 1'b1;
	end

	// Drives one transaction and holds it until accepted, then leaves it raised.
	// Ready is looked at mid-cycle, where it is settled for the coming edge.
	task automatic send(logic kind, logic [2:0] row, logic [2:0] col,
			logic [15:0] capacity, logic [2:0] source, logic [2:0] sink);
		req.valid <= 1'b1;
		req.kind <= kind;
		req.row <= row;
		req.col <= col;
		req.capacity <= capacity;
		req.source <= source;
		req.sink <= sink;
		do @(negedge clk); while (!req.ready);
		@(posedge clk);
		board.note_request(kind, row, col, capacity, source, sink);
	endtask

	task automatic load(int r, int c, logic [15:0] capacity);
		send(KIND_LOAD, 3'(r), 3'(c), capacity, 3'($urandom), 3'($urandom));
	endtask

	task automatic compute(int s, int t);
		send(KIND_COMPUTE, 3'($urandom), 3'($urandom), 16'($urandom), 3'(s), 3'(t));
	endtask

	task automatic idle(int n);
		req.valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic drain();
		idle(1);
		while (board.pending_flows.size() != 0) @(posedge clk);
	endtask

	function automatic logic [15:0] rand_cap();
		case ($urandom_range(0, 3))
			0: return 16'hffff;
			1: return 16'($urandom_range(1, 8));
			default: return 16'($urandom);
		endcase
	endfunction

	int burst;
	int kind_pick;

	initial begin
		board = new();
		cycles = 0;
		stall_mode = 1'b0;
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.kind = KIND_LOAD;
		req.row = '0;
		req.col = '0;
		req.capacity = '0;
		req.source = '0;
		req.sink = '0;
		rsp.ready = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: empty graph, source equals sink, full-capacity extremes.
		compute(0, 7);
		load(0, 7, 16'hffff);
		compute(0, 7);
		compute(7, 7);
		compute(7, 0);
		for (int i = 1; i < 7; i++) begin
			load(0, i, 16'hffff);
			load(i, 7, 16'hffff);
		end
		compute(0, 7);
		load(3, 3, 16'h0001);
		load(7, 0, 16'h8000);
		compute(7, 0);
		compute(3, 3);
		load(0, 7, 16'h0000);
		compute(0, 7);
		drain();

		// Random: mostly small graph rewrites followed by computations.
		burst = $urandom_range(1, 12);
		for (int n = 0; n < 1500; n++) begin
			if (n == 700)
				drain();
			kind_pick = $urandom_range(0, 9);
			if (kind_pick < 3)
				compute($urandom_range(0, 7), $urandom_range(0, 7));
			else if (kind_pick < 4)
				load($urandom_range(0, 7), $urandom_range(0, 7), 16'h0000);
			else
				load($urandom_range(0, 7), $urandom_range(0, 7), rand_cap());
			burst--;
			if (burst == 0) begin
				idle($urandom_range(1, 20));
				burst = $urandom_range(1, 12);
			end
		end
		drain();
		repeat (2000) @(posedge clk);

		if (board.errors == 0 && board.pending_flows.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule
